// ----- rtl/rsvm_pkg.sv -----
// shared types, codes and helpers for the register stack vm execute block
`default_nettype none
package rsvm_pkg;

  localparam int unsigned StackDepthDefault = 1024;

  localparam logic [15:0] RegFirst = 16'd32768;
  localparam logic [15:0] RegLast  = 16'd32775;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_UNIMPL = 3'd2;
  localparam logic [2:0] ST_BADREG = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;
  localparam logic [2:0] ST_UNDER  = 3'd5;
  localparam logic [2:0] ST_OVER   = 3'd6;

  localparam logic [14:0] OP_HALT = 15'd0;
  localparam logic [14:0] OP_SET  = 15'd1;
  localparam logic [14:0] OP_PUSH = 15'd2;
  localparam logic [14:0] OP_POP  = 15'd3;
  localparam logic [14:0] OP_EQ   = 15'd4;
  localparam logic [14:0] OP_GT   = 15'd5;
  localparam logic [14:0] OP_JMP  = 15'd6;
  localparam logic [14:0] OP_JT   = 15'd7;
  localparam logic [14:0] OP_JF   = 15'd8;
  localparam logic [14:0] OP_ADD  = 15'd9;
  localparam logic [14:0] OP_AND  = 15'd12;
  localparam logic [14:0] OP_OR   = 15'd13;
  localparam logic [14:0] OP_NOT  = 15'd14;
  localparam logic [14:0] OP_OUT  = 15'd19;
  localparam logic [14:0] OP_NOOP = 15'd21;

  // operand word classification
  typedef struct packed {
    logic        is_reg;
    logic        bad;
    logic [2:0]  rnum;
    logic [14:0] lit;
  } opnd_t;

  // classified word passed from front to back
  typedef struct packed {
    opnd_t op;
    opnd_t a;
    opnd_t b;
    opnd_t c;
  } instr_t;

  function automatic opnd_t classify(input logic [15:0] w);
    opnd_t o;
    o.is_reg = (w >= RegFirst) && (w <= RegLast);
    o.bad    = (w > RegLast);
    o.rnum   = w[2:0];
    o.lit    = w[14:0];
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rsvm_front.sv -----
// front end: accepts instruction words, classifies operands into a small queue
`default_nettype none
module rsvm_front
  import rsvm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [15:0] in_opcode_word,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  input  wire logic [15:0] in_operand_c,
  output logic             q_valid,
  output instr_t           q_data,
  input  wire logic        q_take
);

  // two entry queue
  instr_t   mem_r [2];
  logic     wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic     wr, rd;

  assign in_full = (cnt_r == 2'd2);
  assign wr      = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign rd      = q_take && q_valid;
  assign q_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= '{op: classify(in_opcode_word), a: classify(in_operand_a),
                       b: classify(in_operand_b), c: classify(in_operand_c)};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rsvm_back.sv -----
// back end: executes one instruction at a time, stack memory read as the word is taken, then execute
`default_nettype none
module rsvm_back
  import rsvm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  instr_t           q_data,
  output logic             q_take,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_status,
  output logic [14:0]      out_next_pc,
  output logic             out_char_valid,
  output logic [7:0]       out_char_out
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(STACK_DEPTH);

  logic [14:0] regs_r [8];
  logic [14:0] stk_r [STACK_DEPTH];
  logic [14:0] rdata_r;
  logic [CW-1:0] cnt_r;
  logic [14:0] pc_r;

  // phase 0: stack read; phase 1: execute
  logic        ph_r;
  instr_t      ins_r;

  // result register / one-deep output
  logic        ov_r;
  logic [2:0]  os_r;
  logic [14:0] opc_r;
  logic        ocv_r;
  logic [7:0]  och_r;

  logic        exec;
  assign out_empty      = !ov_r;
  assign out_status     = os_r;
  assign out_next_pc    = opc_r;
  assign out_char_valid = ocv_r;
  assign out_char_out   = och_r;

  wire out_free = !ov_r || out_pop;
  assign q_take = q_valid && !ph_r;
  assign exec   = ph_r && out_free;

  logic [14:0] opv, av, bv, cv, res, tgt;
  logic [2:0]  st;
  logic [2:0]  len;
  logic        jump, wreg, dopush, dopop, chv;

  always_comb begin
    opv = ins_r.op.is_reg ? regs_r[ins_r.op.rnum] : ins_r.op.lit;
    av  = ins_r.a.is_reg ? regs_r[ins_r.a.rnum] : ins_r.a.lit;
    bv  = ins_r.b.is_reg ? regs_r[ins_r.b.rnum] : ins_r.b.lit;
    cv  = ins_r.c.is_reg ? regs_r[ins_r.c.rnum] : ins_r.c.lit;
    st = ST_OK; len = 3'd1; jump = 1'b0; tgt = bv; res = bv;
    wreg = 1'b0; dopush = 1'b0; dopop = 1'b0; chv = 1'b0;
    if (ins_r.op.bad) begin
      st = ST_RANGE;
    end else begin
      unique case (opv)
        OP_HALT: st = ST_HALT;
        OP_SET, OP_NOT: begin
          len = 3'd3;
          if (!ins_r.a.is_reg) st = ST_BADREG;
          else if (ins_r.b.bad) st = ST_RANGE;
          else begin
            wreg = 1'b1;
            res  = (opv == OP_SET) ? bv : ~bv;
          end
        end
        OP_PUSH: begin
          len = 3'd2;
          if (ins_r.a.bad) st = ST_RANGE;
          else if (cnt_r >= FullCount) st = ST_OVER;
          else dopush = 1'b1;
        end
        OP_POP: begin
          len = 3'd2;
          if (!ins_r.a.is_reg) st = ST_BADREG;
          else if (cnt_r == '0) st = ST_UNDER;
          else begin
            dopop = 1'b1; wreg = 1'b1; res = rdata_r;
          end
        end
        OP_EQ, OP_GT, OP_ADD, OP_AND, OP_OR: begin
          len = 3'd4;
          if (!ins_r.a.is_reg) st = ST_BADREG;
          else if (ins_r.b.bad || ins_r.c.bad) st = ST_RANGE;
          else begin
            wreg = 1'b1;
            case (opv)
              OP_EQ:   res = {14'd0, bv == cv};
              OP_GT:   res = {14'd0, bv > cv};
              OP_ADD:  res = bv + cv;
              OP_AND:  res = bv & cv;
              default: res = bv | cv;
            endcase
          end
        end
        OP_JMP: begin
          len = 3'd2;
          if (ins_r.a.bad) st = ST_RANGE;
          else begin jump = 1'b1; tgt = av; end
        end
        OP_JT, OP_JF: begin
          len = 3'd3;
          if (ins_r.a.bad || ins_r.b.bad) st = ST_RANGE;
          else jump = ((opv == OP_JT) == (av != 15'd0));
        end
        OP_OUT: begin
          len = 3'd2;
          if (ins_r.a.bad) st = ST_RANGE;
          else chv = 1'b1;
        end
        OP_NOOP: ;
        default: st = ST_UNIMPL;
      endcase
    end
  end

  logic ok;
  logic [14:0] npc;
  assign ok  = (st == ST_OK) || (st == ST_HALT);
  assign npc = !ok ? pc_r : (jump ? tgt : pc_r + {12'd0, len});

  // pop address: the top stack entry, one below the stack count
  logic [CW-1:0] cm1;
  assign cm1 = cnt_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!ph_r) rdata_r <= stk_r[cm1[AW-1:0]];
    if (exec && ok && dopush) stk_r[cnt_r[AW-1:0]] <= av;
  end

  always_ff @(posedge clk) begin
    if (q_take) ins_r <= q_data;
    if (exec) begin
      opc_r <= npc;
      os_r  <= st;
      ocv_r <= chv;
      och_r <= chv ? av[7:0] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= 1'b0;
      ov_r  <= 1'b0;
      cnt_r <= '0;
      pc_r  <= '0;
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
    end else begin
      if (q_take) ph_r <= 1'b1;
      else if (exec) ph_r <= 1'b0;
      if (exec) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
      if (exec && ok) begin
        pc_r <= npc;
        if (wreg) regs_r[ins_r.a.rnum] <= res;
        if (dopush) cnt_r <= cnt_r + CW'(1);
        if (dopop)  cnt_r <= cm1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/register_stack_vm_execute.sv -----
// top level of the register stack vm execute block
// usage:
// - input channel: push a word (opcode and three operand words) while full is low
// - the front classifies operand words into a two entry queue
// - the back takes one word, reads the stack memory as it takes the word and
//   executes in its execute phase, writing registers, stack, pc and the result register
// - result channel: status, next pc, char valid and char while empty is low;
//   pop takes it
// - a word passes the front queue, the back's take (stack read) phase and its
//   execute phase before its result is shown in the result register
// - the back takes a new word only after it has executed the last one, set by its read then
//   execute sequence around the single stack memory port
// - reset clears registers, pc, stack count, queues; stack memory is not cleared
// - when pop is held low, the result waits, the back stalls and the queue fills,
//   then full rises
`default_nettype none
module register_stack_vm_execute
  import rsvm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [15:0] in_opcode_word,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  input  wire logic [15:0] in_operand_c,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_status,
  output logic [14:0]      out_next_pc,
  output logic             out_char_valid,
  output logic [7:0]       out_char_out
);

  // queue head between front and back
  logic   q_valid, q_take;
  instr_t q_data;

  rsvm_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_opcode_word, .in_operand_a,
    .in_operand_b, .in_operand_c, .q_valid, .q_data, .q_take
  );

  rsvm_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_take, .out_empty, .out_pop,
    .out_status, .out_next_pc, .out_char_valid, .out_char_out
  );

endmodule
`default_nettype wire

// ----- rtl/rsvm_checker.sv -----
// port level checks for the register stack vm execute block
`default_nettype none
module rsvm_checker
  import rsvm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [2:0]  out_status,
  input wire logic [14:0] out_next_pc,
  input wire logic        out_char_valid,
  input wire logic [7:0]  out_char_out
);

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status <= ST_OVER) else $error("status code out of range");

  a_char_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_char_valid) |-> out_status == ST_OK)
    else $error("char with non-ok status");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_char_valid) |-> out_char_out == 8'd0)
    else $error("char not zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_next_pc))
    else $error("result dropped while stalled");

endmodule

bind register_stack_vm_execute rsvm_checker u_rsvm_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_status, .out_next_pc,
  .out_char_valid, .out_char_out
);
`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the register stack vm execute block
`default_nettype none
module testbench;
  import rsvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = StackDepthDefault;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [15:0] opw;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [15:0] wc;
  } instr_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] npc;
    logic        cv;
    logic [7:0]  ch;
  } exec_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_opcode_word = '0;
  logic [15:0] in_operand_a = '0;
  logic [15:0] in_operand_b = '0;
  logic [15:0] in_operand_c = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_status;
  logic [14:0] out_next_pc;
  logic        out_char_valid;
  logic [7:0]  out_char_out;

  register_stack_vm_execute u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode_word(in_opcode_word), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .in_operand_c(in_operand_c),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_status(out_status), .out_next_pc(out_next_pc),
    .out_char_valid(out_char_valid), .out_char_out(out_char_out)
  );

  // predictor state, a private copy of the machine
  logic [14:0] vm_regs [8] = '{default: '0};
  logic [14:0] vm_stack [DEPTH];
  int unsigned vm_sp = 0;
  logic [14:0] vm_pc = '0;
  // model-side mirror of the stack depth used by the generator
  int unsigned gen_sp;

  instr_word_t  pending_words[$];
  exec_result_t expected_results[$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          in_taken = 1'b0;
  bit          hold_req = 1'b0;
  bit          rx_hold = 1'b0;

  // two-phase clock, 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // resolve a source word: literal or register, above is out of range
  function automatic logic [2:0] src_val(input logic [15:0] w, output logic [14:0] v);
    v = '0;
    if (w < RegFirst) begin
      v = w[14:0];
      return ST_OK;
    end
    if (w <= RegLast) begin
      v = vm_regs[w[2:0]];
      return ST_OK;
    end
    return ST_RANGE;
  endfunction

  // resolve a destination word: must name a register
  function automatic logic [2:0] dst_reg(input logic [15:0] w, output logic [2:0] r);
    r = w[2:0];
    return (w >= RegFirst && w <= RegLast) ? ST_OK : ST_BADREG;
  endfunction

  // execute one instruction on the private copy and return its result
  function automatic exec_result_t execute_instr(input instr_word_t iw);
    exec_result_t res;
    logic [14:0] op, a, b, c, r, tgt;
    logic [2:0]  st, d;
    int unsigned len;
    bit jump;
    res = '0;
    len = 1;
    jump = 0;
    tgt = '0;
    a = '0;
    b = '0;
    c = '0;
    d = '0;
    st = src_val(iw.opw, op);
    if (st == ST_OK) begin
      case (op)
        OP_HALT: st = ST_HALT;
        OP_SET, OP_NOT: begin
          len = 3;
          st = dst_reg(iw.wa, d);
          if (st == ST_OK) st = src_val(iw.wb, b);
          if (st == ST_OK) vm_regs[d] = (op == OP_SET) ? b : ~b;
        end
        OP_PUSH: begin
          len = 2;
          st = src_val(iw.wa, a);
          if (st == ST_OK && vm_sp >= DEPTH) st = ST_OVER;
          if (st == ST_OK) begin
            vm_stack[vm_sp] = a;
            vm_sp++;
          end
        end
        OP_POP: begin
          len = 2;
          st = dst_reg(iw.wa, d);
          if (st == ST_OK && vm_sp == 0) st = ST_UNDER;
          if (st == ST_OK) begin
            vm_sp--;
            vm_regs[d] = vm_stack[vm_sp];
          end
        end
        OP_EQ, OP_GT, OP_ADD, OP_AND, OP_OR: begin
          len = 4;
          st = dst_reg(iw.wa, d);
          if (st == ST_OK) st = src_val(iw.wb, b);
          if (st == ST_OK) st = src_val(iw.wc, c);
          if (st == ST_OK) begin
            case (op)
              OP_EQ:   r = (b == c) ? 15'd1 : 15'd0;
              OP_GT:   r = (b > c) ? 15'd1 : 15'd0;
              OP_ADD:  r = b + c;
              OP_AND:  r = b & c;
              default: r = b | c;
            endcase
            vm_regs[d] = r;
          end
        end
        OP_JMP: begin
          len = 2;
          st = src_val(iw.wa, a);
          if (st == ST_OK) begin
            jump = 1;
            tgt = a;
          end
        end
        OP_JT, OP_JF: begin
          len = 3;
          st = src_val(iw.wa, a);
          if (st == ST_OK) st = src_val(iw.wb, b);
          if (st == ST_OK && ((op == OP_JT) == (a != 0))) begin
            jump = 1;
            tgt = b;
          end
        end
        OP_OUT: begin
          len = 2;
          st = src_val(iw.wa, a);
          if (st == ST_OK) begin
            res.cv = 1'b1;
            res.ch = a[7:0];
          end
        end
        OP_NOOP: ;
        default: st = ST_UNIMPL;
      endcase
    end
    if (st == ST_OK || st == ST_HALT) begin
      if (st == ST_HALT) len = 1;
      vm_pc = jump ? tgt : vm_pc + 15'(len);
      res.npc = vm_pc;
    end else begin
      res.npc = vm_pc;
      res.cv = 1'b0;
      res.ch = '0;
    end
    res.status = st;
    return res;
  endfunction

  // random operand word: mostly literals and registers, some out of range
  function automatic logic [15:0] rand_operand();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return RegFirst + 16'($urandom_range(0, 7));
    if (k < 70) return 16'($urandom_range(0, 32767));
    if (k < 80) return 16'($urandom_range(0, 3));
    if (k < 88) return 16'(32767 - $urandom_range(0, 3));
    if (k < 94) return 16'($urandom_range(32776, 65535));
    return 16'($urandom);
  endfunction

  // opcode word, register-indirect now and then
  function automatic logic [15:0] rand_opcode();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 85) return 16'($urandom_range(0, 21));
    if (k < 92) return RegFirst + 16'($urandom_range(0, 7));
    if (k < 96) return 16'($urandom_range(22, 32767));
    return 16'($urandom_range(32776, 65535));
  endfunction

  // queue a word for the driver
  task automatic add_word(input logic [15:0] o, a, b, c);
    instr_word_t iw;
    iw = '{opw: o, wa: a, wb: b, wc: c};
    pending_words.push_back(iw);
  endtask

  // driver: drives on the falling edge, holds until the word is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && !in_taken) begin
      // keep offering the same word
    end else begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_push        <= 1'b1;
        in_opcode_word <= pending_words[0].opw;
        in_operand_a   <= pending_words[0].wa;
        in_operand_b   <= pending_words[0].wb;
        in_operand_c   <= pending_words[0].wc;
        void'(pending_words.pop_front());
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // accepted words feed the predictor at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_push && !in_full;
    if (rst_n && in_push && !in_full)
      expected_results.push_back(execute_instr('{opw: in_opcode_word, wa: in_operand_a,
                                                 wb: in_operand_b, wc: in_operand_c}));
  end

  // long receiver hold-off, counted here once requested
  initial begin
    wait (hold_req);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // receiver: random pop, nothing while held off
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    exec_result_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d npc %0d cv %0d ch %0d",
                   out_status, out_next_pc, out_char_valid, out_char_out);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status || out_next_pc !== exp_r.npc ||
            out_char_valid !== exp_r.cv || out_char_out !== exp_r.ch) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d npc %0d cv %0d ch %0d, got %0d %0d %0d %0d",
                     exp_r.status, exp_r.npc, exp_r.cv, exp_r.ch,
                     out_status, out_next_pc, out_char_valid, out_char_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // build random words for one phase; push and pop are kept legal on the
  // generator's own depth count so an unwritten stack entry is never read
  task automatic fill_random(input int unsigned n);
    logic [15:0] o, a;
    int unsigned k;
    for (int unsigned i = 0; i < n; i++) begin
      o = rand_opcode();
      a = rand_operand();
      k = $urandom_range(0, 99);
      // well-formed stack traffic in a good share of words
      if (k < 15) begin
        o = 16'(OP_PUSH);
        a = 16'($urandom_range(0, 32767));
      end else if (k < 25) begin
        o = 16'(OP_POP);
        a = RegFirst + 16'($urandom_range(0, 7));
      end
      // register-indirect opcodes could hide a pop, so they are not sent: they become a
      // noop while the depth count is zero and an out-of-range opcode word otherwise
      if (o >= RegFirst && o <= RegLast && gen_sp == 0) o = 16'(OP_NOOP);
      if (o >= RegFirst && o <= RegLast) o = 16'($urandom_range(32776, 65535));
      if (o == 16'(OP_PUSH) && a <= RegLast && gen_sp < DEPTH) gen_sp++;
      if (o == 16'(OP_POP) && a >= RegFirst && a <= RegLast && gen_sp > 0) gen_sp--;
      add_word(o, a, rand_operand(), rand_operand());
    end
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_push || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_sp = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every opcode, field extremes and each fault kind but stack overflow
    add_word(16'(OP_POP), RegFirst, 16'd0, 16'd0);                  // underflow on empty stack
    add_word(16'(OP_SET), RegFirst + 16'd1, 16'd32767, 16'd0);
    add_word(16'(OP_NOT), RegFirst + 16'd2, 16'd0, 16'd0);           // 15-bit inverse
    add_word(16'(OP_ADD), RegFirst + 16'd3, RegFirst + 16'd1, 16'd32767); // wraps
    add_word(16'(OP_EQ), RegFirst + 16'd4, RegFirst + 16'd1, RegFirst + 16'd2);
    add_word(16'(OP_GT), RegFirst + 16'd5, RegFirst + 16'd1, 16'd1);
    add_word(16'(OP_AND), RegLast, 16'h5555, 16'h7fff);
    add_word(16'(OP_OR), RegFirst + 16'd6, 16'h2aaa, 16'h5555);
    add_word(16'(OP_PUSH), RegFirst + 16'd1, 16'd0, 16'd0);
    add_word(16'(OP_POP), RegFirst, 16'd0, 16'd0);
    add_word(16'(OP_OUT), 16'h7fff, 16'd0, 16'd0);
    add_word(16'(OP_OUT), RegFirst + 16'd6, 16'd0, 16'd0);
    add_word(16'(OP_JT), 16'd1, 16'd32767, 16'd0);                  // taken
    add_word(16'(OP_JF), 16'd1, 16'd5, 16'd0);                      // not taken
    add_word(16'(OP_JF), 16'd0, 16'd100, 16'd0);
    add_word(16'(OP_JMP), RegFirst + 16'd3, 16'd0, 16'd0);
    add_word(16'(OP_NOOP), 16'hffff, 16'hffff, 16'hffff);
    add_word(16'(OP_SET), 16'd5, 16'd0, 16'd0);                     // bad destination
    add_word(16'(OP_ADD), RegFirst, 16'd32776, 16'd0);              // source out of range
    add_word(16'hffff, 16'd0, 16'd0, 16'd0);                        // opcode out of range
    add_word(16'd10, 16'd0, 16'd0, 16'd0);                          // unimplemented
    add_word(16'd20, 16'd0, 16'd0, 16'd0);
    add_word(RegFirst + 16'd7, 16'd0, 16'd0, 16'd0);                // opcode from a register
    add_word(16'(OP_HALT), 16'd0, 16'd0, 16'd0);
    drain();

    // stack overflow: fill it completely, then one more push
    for (int unsigned i = 0; i < DEPTH; i++)
      add_word(16'(OP_PUSH), 16'($urandom_range(0, 32767)), 16'd0, 16'd0);
    add_word(16'(OP_PUSH), 16'd1, 16'd0, 16'd0);
    drain();

    // phase 1: sender idles 32 percent, receiver 71
    send_idle_pct = 32;
    recv_idle_pct = 71;
    fill_random(350);
    // long receiver hold-off so the block fills and stalls its input
    hold_req = 1'b1;
    drain();
    // phase 2: the other way round
    send_idle_pct = 71;
    recv_idle_pct = 32;
    fill_random(350);
    drain();
    // phase 3: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(300);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
